/* design/csp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types and codes for the call stack profiler.
// ----------------------------------------------------------------------------
package csp_pkg;

	typedef enum logic [1:0] {
		OP_ENTER = 2'd0,
		OP_LEAVE = 2'd1,
		OP_DRAIN = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_IGNORED    = 2'd1,
		ST_STACK_FULL = 2'd2,
		ST_TABLE_FULL = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_POP_RD,
		S_POP_CHK,
		S_SCAN,
		S_TBL_RD,
		S_UPDATE,
		S_DRN_SCAN,
		S_DRN_RD,
		S_DRN_OUT,
		S_RESP
	} state_t;

	localparam logic [47:0] CALLS_MAX = 48'hFFFF_FFFF_FFFF;

endpackage
`default_nettype wire

/* design/call_stack_profiler_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// call_stack_profiler_unit
// Shadow call stack with a per-method statistics table.
// ----------------------------------------------------------------------------
// One request at a time. Enter pushes onto the stack and then gives its result. Leave reads the
// stack memory, then walks the table one entry per cycle through a single
// id comparator, reads the matching row and updates it, or else claims a
// free row. Drain walks the table entries once and reads each valid row
// through the single table port. Results are held in an output register;
// stall on the result side holds the sequencer.
// ----------------------------------------------------------------------------
module call_stack_profiler_unit #(
	parameter int STACK_DEPTH   = 64,
	parameter int TABLE_ENTRIES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] method_id,
	input  wire logic [63:0] timestamp_ns,
	input  wire logic [47:0] heap_used_bytes,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             row_valid,
	output logic [31:0]      row_method,
	output logic [47:0]      row_calls,
	output logic [63:0]      row_runtime_ns,
	output logic [63:0]      row_alloc_bytes,
	output logic [1:0]       event_status,
	output logic             last
);
	import csp_pkg::*;

	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SDW = $clog2(STACK_DEPTH + 1);
	localparam int TAW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int TCW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [SDW-1:0] SD_FULL = SDW'(STACK_DEPTH);
	localparam logic [TCW-1:0] TE_LAST = TCW'(TABLE_ENTRIES - 1);

	logic [31:0] stk_method_m [STACK_DEPTH];
	logic [63:0] stk_time_m   [STACK_DEPTH];
	logic [47:0] stk_heap_m   [STACK_DEPTH];
	logic [31:0] tbl_method_m [TABLE_ENTRIES];
	logic [47:0] tbl_calls_m  [TABLE_ENTRIES];
	logic [63:0] tbl_rt_m     [TABLE_ENTRIES];
	logic [63:0] tbl_alloc_m  [TABLE_ENTRIES];

	state_t state_q, state_nx;
	logic [SDW-1:0] depth_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [31:0] id_q;
	logic [63:0] ts_q;
	logic [47:0] heap_q;
	logic [31:0] sm_q;
	logic [63:0] st_q;
	logic [47:0] sh_q;
	logic [31:0] tm_q;
	logic [47:0] tc_q;
	logic [63:0] tr_q, ta_q;
	logic [TCW-1:0] idx_q;
	logic [TAW-1:0] slot_q;
	logic free_q, newrow_q, any_q;
	logic [TAW-1:0] free_slot_q;
	logic [1:0] status_q;

	logic           ov_q, orow_q, olast_q;
	logic [31:0]    om_q;
	logic [47:0]    oc_q;
	logic [63:0]    ort_q, oal_q;
	logic [1:0]     ost_q;

	logic out_free, accept, load_out;
	logic [TAW-1:0] idx_a;
	logic more_valid;

	assign out_free = !ov_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign idx_a    = idx_q[TAW-1:0];
	assign load_out = out_free && (state_q == S_DRN_OUT || state_q == S_RESP);

	always_comb begin
		more_valid = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (TCW'(i) > idx_q && valid_q[i])
				more_valid = 1'b1;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op_t'(opcode))
						OP_LEAVE: state_nx = (depth_q == '0) ? S_RESP : S_POP_RD;
						OP_DRAIN: state_nx = S_DRN_SCAN;
						default:  state_nx = S_RESP;
					endcase
				end
			end
			S_POP_RD:  state_nx = S_POP_CHK;
			S_POP_CHK: state_nx = (sm_q == id_q) ? S_SCAN : S_RESP;
			S_SCAN: begin
				if (valid_q[idx_a] && tm_q == id_q)
					state_nx = S_TBL_RD;
				else if (idx_q == TE_LAST)
					state_nx = (free_q || (!valid_q[idx_a])) ? S_UPDATE : S_RESP;
			end
			S_TBL_RD:  state_nx = S_UPDATE;
			S_UPDATE:  state_nx = S_RESP;
			S_DRN_SCAN: begin
				if (valid_q[idx_a])
					state_nx = S_DRN_RD;
				else if (idx_q == TE_LAST)
					state_nx = any_q ? S_IDLE : S_RESP;
			end
			S_DRN_RD:  state_nx = S_DRN_OUT;
			S_DRN_OUT: begin
				if (out_free)
					state_nx = (idx_q == TE_LAST || !more_valid) ? S_IDLE : S_DRN_SCAN;
			end
			S_RESP:    if (out_free) state_nx = S_IDLE;
			default:   state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			depth_q <= '0;
			valid_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load_out)
				ov_q <= 1'b1;
			else if (!out_stall)
				ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && op_t'(opcode) == OP_ENTER && depth_q != SD_FULL)
						depth_q <= depth_q + SDW'(1);
					if (accept && op_t'(opcode) == OP_LEAVE && depth_q != '0)
						depth_q <= depth_q - SDW'(1);
				end
				S_UPDATE: if (newrow_q) valid_q[slot_q] <= 1'b1;
				S_DRN_OUT: begin
					if (out_free)
						valid_q[idx_a] <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				id_q <= method_id; ts_q <= timestamp_ns;
				heap_q <= heap_used_bytes;
				idx_q <= '0; free_q <= 1'b0; any_q <= 1'b0;
				newrow_q <= 1'b0;
				if (accept) begin
					case (op_t'(opcode))
						OP_ENTER: begin
							if (depth_q != SD_FULL) begin
								stk_method_m[SAW'(depth_q)] <= method_id;
								stk_time_m[SAW'(depth_q)]   <= timestamp_ns;
								stk_heap_m[SAW'(depth_q)]   <= heap_used_bytes;
								status_q <= ST_OK;
							end else
								status_q <= ST_STACK_FULL;
						end
						OP_LEAVE: status_q <= ST_IGNORED;
						OP_DRAIN: status_q <= ST_OK;
						default:  status_q <= ST_IGNORED;
					endcase
				end
			end
			S_POP_RD: begin
				sm_q <= stk_method_m[SAW'(depth_q)];
				st_q <= stk_time_m[SAW'(depth_q)];
				sh_q <= stk_heap_m[SAW'(depth_q)];
				tm_q <= tbl_method_m[0];
			end
			S_POP_CHK: status_q <= ST_IGNORED;
			S_SCAN: begin
				if (!valid_q[idx_a] && !free_q) begin
					free_q <= 1'b1;
					free_slot_q <= idx_a;
				end
				if (valid_q[idx_a] && tm_q == id_q) begin
					slot_q <= idx_a;
				end else if (idx_q == TE_LAST) begin
					newrow_q <= 1'b1;
					slot_q <= free_q ? free_slot_q : idx_a;
					tc_q <= '0; tr_q <= '0; ta_q <= '0;
					status_q <= (free_q || !valid_q[idx_a]) ? ST_OK : ST_TABLE_FULL;
				end else begin
					idx_q <= idx_q + TCW'(1);
					tm_q <= tbl_method_m[TAW'(idx_q + TCW'(1))];
				end
			end
			S_TBL_RD: begin
				tc_q <= tbl_calls_m[slot_q];
				tr_q <= tbl_rt_m[slot_q];
				ta_q <= tbl_alloc_m[slot_q];
			end
			S_UPDATE: begin
				tbl_method_m[slot_q] <= id_q;
				tbl_calls_m[slot_q]  <= (tc_q == CALLS_MAX) ? tc_q : tc_q + 48'd1;
				tbl_rt_m[slot_q]     <= tr_q + (ts_q - st_q);
				tbl_alloc_m[slot_q]  <= (heap_q > sh_q) ?
					ta_q + {16'd0, heap_q - sh_q} : ta_q;
				status_q <= ST_OK;
			end
			S_DRN_SCAN: begin
				if (!valid_q[idx_a] && idx_q != TE_LAST)
					idx_q <= idx_q + TCW'(1);
			end
			S_DRN_RD: begin
				any_q <= 1'b1;
				tm_q <= tbl_method_m[idx_a];
				tc_q <= tbl_calls_m[idx_a];
				tr_q <= tbl_rt_m[idx_a];
				ta_q <= tbl_alloc_m[idx_a];
			end
			S_DRN_OUT: begin
				if (out_free && idx_q != TE_LAST)
					idx_q <= idx_q + TCW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DRN_OUT && out_free) begin
			orow_q <= 1'b1; om_q <= tm_q; oc_q <= tc_q; ort_q <= tr_q; oal_q <= ta_q;
			ost_q <= ST_OK; olast_q <= (idx_q == TE_LAST) || !more_valid;
		end else if (state_q == S_RESP && out_free) begin
			orow_q <= 1'b0; om_q <= '0; oc_q <= '0; ort_q <= '0; oal_q <= '0;
			ost_q <= status_q; olast_q <= 1'b1;
		end
	end

	assign out_valid       = ov_q;
	assign row_valid       = orow_q;
	assign row_method      = om_q;
	assign row_calls       = oc_q;
	assign row_runtime_ns  = ort_q;
	assign row_alloc_bytes = oal_q;
	assign event_status    = ost_q;
	assign last            = olast_q;

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= SD_FULL) else $error("stack depth out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && out_stall |=> ov_q && $stable(olast_q)) else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall) else $error("accepted while busy");
	a_row_ok: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && orow_q |-> ost_q == ST_OK) else $error("row with bad status");

endmodule
`default_nettype wire
